// ===== design/dhpd_pkg.sv =====
// dhpd_pkg: shared widths, codes and types of the differential heading PD controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package dhpd_pkg;

   localparam int HEADING_WIDTH = 24;
   localparam int DRIVE_WIDTH   = 16;
   localparam int WALL_PERIOD   = 100;

   localparam int WALL_CNT_WIDTH = $clog2(WALL_PERIOD + 1);

   // port field widths
   localparam int OP_WIDTH        = 2;
   localparam int HEADING_IN_WIDTH = 24;
   localparam int SPEED_WIDTH     = 16;
   localparam int KIND_WIDTH      = 2;
   localparam int OUT_DRIVE_WIDTH = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // datapath widths
   localparam int FRAC_BITS   = 20;
   localparam int SERR_WIDTH  = 18;
   localparam int SPROD_WIDTH = SERR_WIDTH + GAIN_WIDTH + 1;
   localparam int S_SHIFT     = 17;
   localparam int S_WIDTH     = 18;
   localparam int H_WIDTH     = HEADING_WIDTH + GAIN_WIDTH + 3;
   localparam int NUM_WIDTH   =
      ((H_WIDTH > S_WIDTH + FRAC_BITS) ? H_WIDTH : S_WIDTH + FRAC_BITS) + 1;
   localparam int DELTA_WIDTH = NUM_WIDTH - FRAC_BITS;
   localparam int SUM_BASE    = (DELTA_WIDTH > DRIVE_WIDTH) ? DELTA_WIDTH : DRIVE_WIDTH;
   localparam int SUM_WIDTH   = ((SUM_BASE > LIMIT_WIDTH + 1) ? SUM_BASE : LIMIT_WIDTH + 1) + 1;
   localparam int DRIVE_CAP   = (2 ** (DRIVE_WIDTH - 1)) - 1;

   // heading constants, Q.8
   localparam int SHIFT_QUARTER = 22549;
   localparam int SHIFT_HALF    = 45099;
   localparam int WALL_NUDGE    = 1253;
   localparam int THR_RIGHT     = 2560;
   localparam int THR_OTHER     = 256;
   localparam logic [GAIN_WIDTH-1:0] HALF_KP = GAIN_WIDTH'(41);
   localparam logic [GAIN_WIDTH-1:0] HALF_KD = GAIN_WIDTH'(410);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_STRAIGHT   = 2'd0,
      OP_TURN       = 2'd1,
      OP_TURN_START = 2'd2,
      OP_WALL       = 2'd3
   } op_type;

   localparam logic [KIND_WIDTH-1:0] KIND_RIGHT   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LEFT    = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_HALF    = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_IGNORED = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_SPEED = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRAIGHT_KP  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRAIGHT_KD  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_KP      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_KD      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE_LIMIT  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_LIMIT   = 3'd7;

   typedef logic signed [HEADING_WIDTH-1:0]   heading_type;
   typedef logic signed [DRIVE_WIDTH-1:0]     drive_type;
   typedef logic signed [OUT_DRIVE_WIDTH-1:0] out_drive_type;
   typedef logic [WALL_CNT_WIDTH-1:0]         wall_cnt_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] target_speed;
      logic [GAIN_WIDTH-1:0]  speed_gain;
      logic [GAIN_WIDTH-1:0]  straight_kp;
      logic [GAIN_WIDTH-1:0]  straight_kd;
      logic [GAIN_WIDTH-1:0]  turn_kp;
      logic [GAIN_WIDTH-1:0]  turn_kd;
      logic [LIMIT_WIDTH-1:0] drive_limit;
      logic [LIMIT_WIDTH-1:0] turn_limit;
   } cfg_type;

   typedef struct packed {
      op_type                              operation;
      logic signed [HEADING_IN_WIDTH-1:0]  heading;
      logic signed [SPEED_WIDTH-1:0]       left_speed;
      logic signed [SPEED_WIDTH-1:0]       right_speed;
      logic [KIND_WIDTH-1:0]               turn_kind;
      logic                                left_near;
      logic                                right_near;
   } item_type;

   typedef struct packed {
      heading_type           target_heading;
      heading_type           last_error;
      drive_type             right_cmd;
      drive_type             left_cmd;
      wall_cnt_type          wall_cnt;
      logic [KIND_WIDTH-1:0] latched_turn;
   } state_type;

   typedef struct packed {
      out_drive_type right_drive;
      out_drive_type left_drive;
      logic          turn_done;
      logic          saturated;
   } result_type;

endpackage

`default_nettype wire

// ===== design/dhpd_csr.sv =====
// dhpd_csr: configuration register file, write-only, reset to the default gains and limits.
// Depends on dhpd_pkg.
`default_nettype none

module dhpd_csr import dhpd_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed <= LIMIT_WIDTH'(2000);
         cfg_ff.speed_gain   <= GAIN_WIDTH'(205);
         cfg_ff.straight_kp  <= GAIN_WIDTH'(123);
         cfg_ff.straight_kd  <= GAIN_WIDTH'(20480);
         cfg_ff.turn_kp      <= GAIN_WIDTH'(205);
         cfg_ff.turn_kd      <= GAIN_WIDTH'(20480);
         cfg_ff.drive_limit  <= LIMIT_WIDTH'(255);
         cfg_ff.turn_limit   <= LIMIT_WIDTH'(128);
      end else if (write_enable) begin
         case (index)
            CSR_TARGET_SPEED: cfg_ff.target_speed <= data[LIMIT_WIDTH-1:0];
            CSR_SPEED_GAIN:   cfg_ff.speed_gain   <= data[GAIN_WIDTH-1:0];
            CSR_STRAIGHT_KP:  cfg_ff.straight_kp  <= data[GAIN_WIDTH-1:0];
            CSR_STRAIGHT_KD:  cfg_ff.straight_kd  <= data[GAIN_WIDTH-1:0];
            CSR_TURN_KP:      cfg_ff.turn_kp      <= data[GAIN_WIDTH-1:0];
            CSR_TURN_KD:      cfg_ff.turn_kd      <= data[GAIN_WIDTH-1:0];
            CSR_DRIVE_LIMIT:  cfg_ff.drive_limit  <= data[LIMIT_WIDTH-1:0];
            CSR_TURN_LIMIT:   cfg_ff.turn_limit   <= data[LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/dhpd_datapath.sv =====
// dhpd_datapath: single-pass controller update: heading PD, speed P, clamp, turn and wall logic.
// Depends on dhpd_pkg.
`default_nettype none

module dhpd_datapath import dhpd_pkg::*; (
   input  item_type   item,
   input  state_type  cur,
   input  cfg_type    cfg,
   output state_type  nxt,
   output result_type res
);

   typedef logic signed [H_WIDTH-1:0]     h_type;
   typedef logic signed [NUM_WIDTH-1:0]   num_type;
   typedef logic signed [DELTA_WIDTH-1:0] delta_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [HEADING_WIDTH:0]        mag_type;

   typedef struct packed {
      logic      sat;
      drive_type cmd;
   } drive_upd_type;

   function automatic delta_type trunc_frac(num_type v);
      num_type adj;
      num_type q;
      adj = v + (v[NUM_WIDTH-1] ? num_type'((2 ** FRAC_BITS) - 1) : num_type'(0));
      q   = adj >>> FRAC_BITS;
      return q[DELTA_WIDTH-1:0];
   endfunction

   function automatic drive_upd_type add_drive(drive_type cmd, delta_type delta,
                                               logic [LIMIT_WIDTH-1:0] limit);
      sum_type       n;
      sum_type       lim;
      sum_type       cap;
      drive_upd_type r;
      n   = sum_type'(cmd) + sum_type'(delta);
      lim = sum_type'($signed({1'b0, limit}));
      cap = sum_type'(DRIVE_CAP);
      if (lim > cap) lim = cap;
      r.sat = 1'b0;
      if (n > lim) begin
         n     = lim;
         r.sat = 1'b1;
      end
      if (n < -lim) begin
         n     = -lim;
         r.sat = 1'b1;
      end
      r.cmd = n[DRIVE_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic is_settled(heading_type e, logic [KIND_WIDTH-1:0] kind);
      mag_type ext;
      mag_type mag;
      ext = {e[HEADING_WIDTH-1], e};
      mag = ext[HEADING_WIDTH] ? (~ext + mag_type'(1)) : ext;
      return mag <= ((kind == KIND_RIGHT) ? mag_type'(THR_RIGHT) : mag_type'(THR_OTHER));
   endfunction

   heading_type                   head;
   heading_type                   err;
   logic signed [HEADING_WIDTH:0] derr;
   logic [GAIN_WIDTH-1:0]         kp;
   logic [GAIN_WIDTH-1:0]         kd;
   h_type                         h;
   logic signed [SERR_WIDTH-1:0]  serr;
   logic signed [SPROD_WIDTH-1:0] sprod;
   logic signed [SPROD_WIDTH-1:0] sprod_adj;
   logic signed [S_WIDTH-1:0]     s_val;
   num_type                       s_num;
   num_type                       h_num;
   delta_type                     delta_r;
   delta_type                     delta_l;
   logic [LIMIT_WIDTH-1:0]        limit;
   drive_upd_type                 upd_r;
   drive_upd_type                 upd_l;
   heading_type                   shift;
   heading_type                   new_target;
   logic                          done;
   logic                          sat;

   assign head = heading_type'(item.heading);
   assign err  = cur.target_heading - head;
   assign derr = {err[HEADING_WIDTH-1], err} - {cur.last_error[HEADING_WIDTH-1], cur.last_error};

   always_comb begin
      if (item.operation == OP_STRAIGHT) begin
         kp = cfg.straight_kp;
         kd = cfg.straight_kd;
      end else if (cur.latched_turn == KIND_HALF) begin
         kp = HALF_KP;
         kd = HALF_KD;
      end else begin
         kp = cfg.turn_kp;
         kd = cfg.turn_kd;
      end
   end

   assign h = $signed({1'b0, kp}) * err + $signed({1'b0, kd}) * derr;

   assign serr = $signed({2'b00, cfg.target_speed, 1'b0})
               - $signed({{2{item.left_speed[SPEED_WIDTH-1]}}, item.left_speed})
               - $signed({{2{item.right_speed[SPEED_WIDTH-1]}}, item.right_speed});
   assign sprod     = $signed({1'b0, cfg.speed_gain}) * serr;
   assign sprod_adj = sprod + (sprod[SPROD_WIDTH-1] ?
                      SPROD_WIDTH'((2 ** S_SHIFT) - 1) : SPROD_WIDTH'(0));
   assign s_val     = S_WIDTH'(sprod_adj >>> S_SHIFT);

   // turn ticks carry no speed term
   assign s_num = (item.operation == OP_STRAIGHT) ? (num_type'(s_val) <<< FRAC_BITS)
                                                  : num_type'(0);
   assign h_num   = num_type'(h);
   assign delta_r = trunc_frac(s_num + h_num);
   assign delta_l = trunc_frac(s_num - h_num);
   assign limit   = (item.operation == OP_STRAIGHT) ? cfg.drive_limit : cfg.turn_limit;
   assign upd_r   = add_drive(cur.right_cmd, delta_r, limit);
   assign upd_l   = add_drive(cur.left_cmd, delta_l, limit);

   always_comb begin
      case (item.turn_kind)
         KIND_RIGHT: shift = heading_type'(-SHIFT_QUARTER);
         KIND_LEFT:  shift = heading_type'(SHIFT_QUARTER);
         KIND_HALF:  shift = heading_type'(SHIFT_HALF);
         default:    shift = heading_type'(0);
      endcase
   end

   assign new_target = cur.target_heading + shift;

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      sat  = 1'b0;
      case (item.operation)
         OP_STRAIGHT, OP_TURN: begin
            nxt.right_cmd  = upd_r.cmd;
            nxt.left_cmd   = upd_l.cmd;
            nxt.last_error = err;
            sat            = upd_r.sat | upd_l.sat;
            if (item.operation == OP_TURN) done = is_settled(err, cur.latched_turn);
         end
         OP_TURN_START: begin
            if (item.turn_kind != KIND_IGNORED) begin
               nxt.target_heading = new_target;
               nxt.latched_turn   = item.turn_kind;
               done               = is_settled(new_target - head, item.turn_kind);
            end
         end
         OP_WALL: begin
            if (cur.wall_cnt >= wall_cnt_type'(WALL_PERIOD)) begin
               nxt.wall_cnt = '0;
               if (item.left_near && !item.right_near)
                  nxt.target_heading = cur.target_heading - heading_type'(WALL_NUDGE);
               else if (item.right_near && !item.left_near)
                  nxt.target_heading = cur.target_heading + heading_type'(WALL_NUDGE);
            end else begin
               nxt.wall_cnt = cur.wall_cnt + wall_cnt_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign res.right_drive = out_drive_type'(nxt.right_cmd);
   assign res.left_drive  = out_drive_type'(nxt.left_cmd);
   assign res.turn_done   = done;
   assign res.saturated   = sat;

endmodule

`default_nettype wire

// ===== design/differential_heading_pd_controller_top.sv =====
// differential_heading_pd_controller_top: input register, controller state, result register.
// Depends on dhpd_pkg, dhpd_csr and dhpd_datapath.
`default_nettype none

// Heading PD / speed P controller for a differential drive. Each transfer on the req_ channel
// is one control tick (straight, turn, turn start or wall tick) and yields exactly one transfer
// on the rsp_ channel carrying the drive commands after the update. Throughput is one item per
// clock while rsp_ does not stall: the item sits in an input register, the whole update (three
// multipliers, the truncating shift and the clamp) runs in one combinational pass, and the
// controller state and result register load in the same cycle. rsp_valid rises once the item
// moves on into a free result register; a stalled rsp_ holds it in the input register. The user
// must write the configuration via csr_ only with no item in flight (unenforced); no read-back.
module differential_heading_pd_controller_top import dhpd_pkg::*; (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [OP_WIDTH-1:0]                req_operation,
   input  wire logic signed [HEADING_IN_WIDTH-1:0] req_heading,
   input  wire logic signed [SPEED_WIDTH-1:0]      req_left_speed,
   input  wire logic signed [SPEED_WIDTH-1:0]      req_right_speed,
   input  wire logic [KIND_WIDTH-1:0]              req_turn_kind,
   input  wire logic                               req_left_near,
   input  wire logic                               req_right_near,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [OUT_DRIVE_WIDTH-1:0]       rsp_right_drive,
   output logic signed [OUT_DRIVE_WIDTH-1:0]       rsp_left_drive,
   output logic                                    rsp_turn_done,
   output logic                                    rsp_saturated,
   input  wire logic                               csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0]         csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]          csr_data
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   stg_item_ff;
   logic       stg_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       advance;

   dhpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .data         (csr_data),
      .cfg          (cfg)
   );

   dhpd_datapath u_datapath (
      .item (stg_item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (result_in)
   );

   assign req_item.operation   = op_type'(req_operation);
   assign req_item.heading     = req_heading;
   assign req_item.left_speed  = req_left_speed;
   assign req_item.right_speed = req_right_speed;
   assign req_item.turn_kind   = req_turn_kind;
   assign req_item.left_near   = req_left_near;
   assign req_item.right_near  = req_right_near;

   assign advance   = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stg_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) stg_item_ff <= req_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_data_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_right_drive = rsp_data_ff.right_drive;
   assign rsp_left_drive  = rsp_data_ff.left_drive;
   assign rsp_turn_done   = rsp_data_ff.turn_done;
   assign rsp_saturated   = rsp_data_ff.saturated;

   a_wall_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.wall_cnt <= wall_cnt_type'(WALL_PERIOD))
      else $error("wall tick counter past its period");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stg_valid_ff))
      else $error("result appeared without a staged item");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && rsp_valid_ff && !rsp_ready |=> stg_valid_ff && $stable(state_ff))
      else $error("staged item or state lost while result stalled");

endmodule

`default_nettype wire
